### design/gjs_pkg.sv
package gjs_pkg;

    localparam logic [1:0] FOP_MUL = 2'd0;
    localparam logic [1:0] FOP_SUB = 2'd1;
    localparam logic [1:0] FOP_DIV = 2'd2;

    localparam logic [31:0] QNAN_POS = 32'h7FC0_0000;
    localparam logic [31:0] QNAN_DEF = 32'hFFC0_0000;
    localparam logic [31:0] QUIET_BIT = 32'h0040_0000;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } fpu_req_t;

endpackage

### design/gauss_jordan_solver_core.sv
// Channel     Direction  Handshake          Payload
// config      in         cfg_we             cfg_wdata (unknowns in use, 6 bits)
// s (coeffs)  in         s_valid / s_ready  s_coefficient (float32, row-major)
// m (results) out        m_valid / m_ready  m_solution_value, m_unknown_index, m_last_value
//
// Loading takes one coefficient per cycle into the matrix RAM; n*(n+1) per run.
// Elimination then runs n*(n+1) divides and n*(n-1)*(n+1) multiply-subtract pairs
// through one shared FPU; a zero, infinite or NaN operand skips the FPU's arithmetic
// states, and an underflow adds right shifts in normalisation.
// s_ready is low during elimination. Each result is read, registered and held until m_ready.
// Reset is synchronous, active low, restores n = MAX_UNKNOWNS with an empty load, no RAM clear.
module gauss_jordan_solver_core
    import gjs_pkg::*;
#(
    parameter int MAX_UNKNOWNS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_coefficient,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_solution_value,
    output logic [4:0]  m_unknown_index,
    output logic        m_last_value
);

    localparam int DEPTH = MAX_UNKNOWNS * (MAX_UNKNOWNS + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(MAX_UNKNOWNS + 1);

    localparam logic [3:0] S_LOAD    = 4'd0;
    localparam logic [3:0] S_PIV_RD  = 4'd1;
    localparam logic [3:0] S_PIV_LD  = 4'd2;
    localparam logic [3:0] S_DIV_RD  = 4'd3;
    localparam logic [3:0] S_DIV_GO  = 4'd4;
    localparam logic [3:0] S_DIV_WT  = 4'd5;
    localparam logic [3:0] S_ROW_CHK = 4'd6;
    localparam logic [3:0] S_FAC_LD  = 4'd7;
    localparam logic [3:0] S_MS_RD   = 4'd8;
    localparam logic [3:0] S_MS_MUL  = 4'd9;
    localparam logic [3:0] S_MS_MWT  = 4'd10;
    localparam logic [3:0] S_MS_SUB  = 4'd11;
    localparam logic [3:0] S_MS_SWT  = 4'd12;
    localparam logic [3:0] S_OUT_RD  = 4'd13;
    localparam logic [3:0] S_OUT_LD  = 4'd14;
    localparam logic [3:0] S_OUT_WT  = 4'd15;

    logic [3:0]    state_reg, state_next;
    logic [NW-1:0] n_reg, n_next;
    logic [AW-1:0] last_reg, last_next;
    logic [AW-1:0] load_reg, load_next;
    logic [NW-1:0] i_reg, i_next;
    logic [NW-1:0] j_reg, j_next;
    logic [NW-1:0] k_reg, k_next;
    logic [AW-1:0] ibase_reg, ibase_next;
    logic [AW-1:0] jbase_reg, jbase_next;
    logic [31:0]   pivot_reg, pivot_next;
    logic [31:0]   factor_reg, factor_next;
    logic [31:0]   prod_reg, prod_next;
    logic [31:0]   out_reg, out_next;

    logic [6:0]    raw7;
    logic [NW-1:0] n_cfg;
    logic [AW-1:0] wstep;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata;

    fpu_req_t      fpu_req;
    logic [31:0]   fpu_b;
    logic          fpu_done;
    logic [31:0]   fpu_result;

    assign raw7  = {1'b0, cfg_wdata};
    assign n_cfg = (raw7 == 7'd0) ? NW'(1) :
                   (int'(raw7) > MAX_UNKNOWNS) ? NW'(MAX_UNKNOWNS) : NW'(raw7);
    assign wstep = AW'(n_reg) + AW'(1);

    assign s_ready = state_reg == S_LOAD;
    assign m_valid = state_reg == S_OUT_WT;

    always_comb begin
        case (state_reg)
            S_PIV_RD:  ram_raddr = ibase_reg + AW'(i_reg);
            S_DIV_RD:  ram_raddr = ibase_reg + AW'(k_reg);
            S_ROW_CHK: ram_raddr = jbase_reg + AW'(i_reg);
            S_MS_RD:   ram_raddr = ibase_reg + AW'(k_reg);
            S_MS_MUL:  ram_raddr = jbase_reg + AW'(k_reg);
            S_MS_MWT:  ram_raddr = jbase_reg + AW'(k_reg);
            S_OUT_RD:  ram_raddr = ibase_reg + AW'(n_reg);
            default:   ram_raddr = '0;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = load_reg;
        ram_wdata = s_coefficient;
        if (state_reg == S_LOAD) begin
            ram_we = s_valid;
        end else if (state_reg == S_DIV_WT) begin
            ram_we    = fpu_done;
            ram_waddr = ibase_reg + AW'(k_reg);
            ram_wdata = fpu_result;
        end else if (state_reg == S_MS_SWT) begin
            ram_we    = fpu_done;
            ram_waddr = jbase_reg + AW'(k_reg);
            ram_wdata = fpu_result;
        end
    end

    always_comb begin
        fpu_req.start = 1'b0;
        fpu_req.op    = FOP_DIV;
        fpu_b         = pivot_reg;
        case (state_reg)
            S_DIV_GO: begin
                fpu_req.start = 1'b1;
            end
            S_MS_MUL: begin
                fpu_req.start = 1'b1;
                fpu_req.op    = FOP_MUL;
                fpu_b         = factor_reg;
            end
            S_MS_SUB: begin
                fpu_req.start = 1'b1;
                fpu_req.op    = FOP_SUB;
                fpu_b         = prod_reg;
            end
            default: begin
                fpu_req.start = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        n_next      = n_reg;
        last_next   = last_reg;
        load_next   = load_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        ibase_next  = ibase_reg;
        jbase_next  = jbase_reg;
        pivot_next  = pivot_reg;
        factor_next = factor_reg;
        prod_next   = prod_reg;
        out_next    = out_reg;
        case (state_reg)
            S_LOAD: begin
                if (s_valid) begin
                    if (load_reg == last_reg) begin
                        load_next  = '0;
                        i_next     = '0;
                        ibase_next = '0;
                        state_next = S_PIV_RD;
                    end else begin
                        load_next = load_reg + AW'(1);
                    end
                end
            end
            S_PIV_RD: begin
                state_next = S_PIV_LD;
            end
            S_PIV_LD: begin
                pivot_next = ram_rdata;
                k_next     = '0;
                state_next = S_DIV_RD;
            end
            S_DIV_RD: begin
                state_next = S_DIV_GO;
            end
            S_DIV_GO: begin
                state_next = S_DIV_WT;
            end
            S_DIV_WT: begin
                if (fpu_done) begin
                    if (k_reg == n_reg) begin
                        j_next     = '0;
                        jbase_next = '0;
                        state_next = S_ROW_CHK;
                    end else begin
                        k_next     = k_reg + NW'(1);
                        state_next = S_DIV_RD;
                    end
                end
            end
            S_ROW_CHK: begin
                if (j_reg == n_reg) begin
                    if (i_reg + NW'(1) == n_reg) begin
                        i_next     = '0;
                        ibase_next = '0;
                        state_next = S_OUT_RD;
                    end else begin
                        i_next     = i_reg + NW'(1);
                        ibase_next = ibase_reg + wstep;
                        state_next = S_PIV_RD;
                    end
                end else if (j_reg == i_reg) begin
                    j_next     = j_reg + NW'(1);
                    jbase_next = jbase_reg + wstep;
                end else begin
                    state_next = S_FAC_LD;
                end
            end
            S_FAC_LD: begin
                factor_next = ram_rdata;
                k_next      = '0;
                state_next  = S_MS_RD;
            end
            S_MS_RD: begin
                state_next = S_MS_MUL;
            end
            S_MS_MUL: begin
                state_next = S_MS_MWT;
            end
            S_MS_MWT: begin
                if (fpu_done) begin
                    prod_next  = fpu_result;
                    state_next = S_MS_SUB;
                end
            end
            S_MS_SUB: begin
                state_next = S_MS_SWT;
            end
            S_MS_SWT: begin
                if (fpu_done) begin
                    if (k_reg == n_reg) begin
                        j_next     = j_reg + NW'(1);
                        jbase_next = jbase_reg + wstep;
                        state_next = S_ROW_CHK;
                    end else begin
                        k_next     = k_reg + NW'(1);
                        state_next = S_MS_RD;
                    end
                end
            end
            S_OUT_RD: begin
                state_next = S_OUT_LD;
            end
            S_OUT_LD: begin
                out_next   = ram_rdata;
                state_next = S_OUT_WT;
            end
            S_OUT_WT: begin
                if (m_ready) begin
                    if (i_reg + NW'(1) == n_reg) begin
                        state_next = S_LOAD;
                    end else begin
                        i_next     = i_reg + NW'(1);
                        ibase_next = ibase_reg + wstep;
                        state_next = S_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
        if (cfg_we) begin
            n_next    = n_cfg;
            last_next = AW'(int'(n_cfg) * (int'(n_cfg) + 1) - 1);
            load_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            n_reg     <= NW'(MAX_UNKNOWNS);
            last_reg  <= AW'(DEPTH - 1);
            load_reg  <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            ibase_reg <= '0;
            jbase_reg <= '0;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
            last_reg  <= last_next;
            load_reg  <= load_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            ibase_reg <= ibase_next;
            jbase_reg <= jbase_next;
        end
        pivot_reg  <= pivot_next;
        factor_reg <= factor_next;
        prod_reg   <= prod_next;
        out_reg    <= out_next;
    end

    gjs_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_matrix_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gjs_fpu u_fpu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (fpu_req),
        .op_a    (ram_rdata),
        .op_b    (fpu_b),
        .done    (fpu_done),
        .result  (fpu_result)
    );

    assign m_solution_value = out_reg;
    assign m_unknown_index  = 5'(i_reg);
    assign m_last_value     = i_reg + NW'(1) == n_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result channels active together");

    a_ready_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_value) |=> s_ready)
        else $error("not ready after final result transaction");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        fpu_done |-> (state_reg == S_DIV_WT || state_reg == S_MS_MWT ||
                      state_reg == S_MS_SWT))
        else $error("fpu result outside a wait state");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (i_reg < n_reg))
        else $error("result index beyond unknowns in use");

endmodule

### design/gjs_ram.sv
module gjs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1056
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/gjs_fpu.sv
module gjs_fpu
    import gjs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  fpu_req_t    req,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic        done,
    output logic [31:0] result
);

    localparam logic [2:0] F_IDLE    = 3'd0;
    localparam logic [2:0] F_SETUP   = 3'd1;
    localparam logic [2:0] F_ALIGN   = 3'd2;
    localparam logic [2:0] F_PRENORM = 3'd3;
    localparam logic [2:0] F_DIVIDE  = 3'd4;
    localparam logic [2:0] F_NORM    = 3'd5;
    localparam logic [2:0] F_ROUND   = 3'd6;
    localparam logic [2:0] F_DONE    = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic [1:0]         op_reg, op_next;
    logic [31:0]        a_reg, a_next;
    logic [31:0]        b_reg, b_next;
    logic               sign_reg, sign_next;
    logic               esub_reg, esub_next;
    logic signed [11:0] exp_reg, exp_next;
    logic [47:0]        man_reg, man_next;
    logic               sticky_reg, sticky_next;
    logic [23:0]        ma_reg, ma_next;
    logic [23:0]        mb_reg, mb_next;
    logic signed [11:0] ea_reg, ea_next;
    logic signed [11:0] eb_reg, eb_next;
    logic [25:0]        rem_reg, rem_next;
    logic [25:0]        quo_reg, quo_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [31:0]        res_reg, res_next;

    logic               sa, sb, bs_eff;
    logic               a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
    logic [23:0]        a_man, b_man;
    logic signed [11:0] a_e, b_e;
    logic [47:0]        prod;
    logic               a_big;

    logic signed [11:0] diff_e;
    logic [47:0]        big_m, small_m, small_mask, small_sh, sum_m;

    logic               rem_ge;
    logic [25:0]        rem_diff;

    logic               guard, st, up;
    logic [24:0]        m25;
    logic signed [11:0] exp2;
    logic [31:0]        rounded;

    assign sa     = a_reg[31];
    assign sb     = b_reg[31];
    assign bs_eff = ~b_reg[31];
    assign a_nan  = (a_reg[30:23] == 8'hFF) && (a_reg[22:0] != 23'd0);
    assign a_inf  = (a_reg[30:23] == 8'hFF) && (a_reg[22:0] == 23'd0);
    assign a_zero = (a_reg[30:0] == 31'd0);
    assign b_nan  = (b_reg[30:23] == 8'hFF) && (b_reg[22:0] != 23'd0);
    assign b_inf  = (b_reg[30:23] == 8'hFF) && (b_reg[22:0] == 23'd0);
    assign b_zero = (b_reg[30:0] == 31'd0);
    assign a_man  = {a_reg[30:23] != 8'd0, a_reg[22:0]};
    assign b_man  = {b_reg[30:23] != 8'd0, b_reg[22:0]};
    assign a_e    = $signed({4'b0, (a_reg[30:23] == 8'd0) ? 8'd1 : a_reg[30:23]});
    assign b_e    = $signed({4'b0, (b_reg[30:23] == 8'd0) ? 8'd1 : b_reg[30:23]});
    assign prod   = a_man * b_man;
    assign a_big  = (a_e > b_e) || ((a_e == b_e) && (a_man >= b_man));

    always_comb begin
        diff_e     = ea_reg - eb_reg;
        big_m      = {1'b0, ma_reg, 23'd0};
        small_m    = {1'b0, mb_reg, 23'd0};
        small_mask = ~({48{1'b1}} << diff_e[5:0]);
        if (diff_e > 12'sd47) begin
            small_sh = 48'd1;
        end else begin
            small_sh = (small_m >> diff_e[5:0]) | {47'd0, |(small_m & small_mask)};
        end
        sum_m = esub_reg ? (big_m - small_sh) : (big_m + small_sh);
    end

    assign rem_ge   = rem_reg >= {2'b0, mb_reg};
    assign rem_diff = rem_ge ? (rem_reg - {2'b0, mb_reg}) : rem_reg;

    always_comb begin
        guard = man_reg[22];
        st    = (|man_reg[21:0]) | sticky_reg;
        up    = guard & (st | man_reg[23]);
        m25   = {1'b0, man_reg[46:23]} + {24'd0, up};
        if (m25[24]) begin
            exp2 = exp_reg + 12'sd1;
        end else begin
            exp2 = exp_reg;
        end
        if (exp2 >= 12'sd255) begin
            rounded = {sign_reg, 8'hFF, 23'd0};
        end else if (m25[24]) begin
            rounded = {sign_reg, exp2[7:0], 23'd0};
        end else begin
            rounded = {sign_reg, m25[23] ? exp2[7:0] : 8'd0, m25[22:0]};
        end
    end

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        sign_next   = sign_reg;
        esub_next   = esub_reg;
        exp_next    = exp_reg;
        man_next    = man_reg;
        sticky_next = sticky_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        ea_next     = ea_reg;
        eb_next     = eb_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        res_next    = res_reg;
        case (state_reg)
            F_IDLE: begin
                if (req.start) begin
                    a_next     = op_a;
                    b_next     = op_b;
                    op_next    = req.op;
                    state_next = F_SETUP;
                end
            end
            F_SETUP: begin
                state_next = F_DONE;
                case (op_reg)
                    FOP_MUL: begin
                        if (a_nan) begin
                            res_next = a_reg | QUIET_BIT;
                        end else if (b_nan) begin
                            res_next = b_reg | QUIET_BIT;
                        end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                            res_next = QNAN_DEF;
                        end else if (a_inf || b_inf) begin
                            res_next = {sa ^ sb, 8'hFF, 23'd0};
                        end else if (a_zero || b_zero) begin
                            res_next = {sa ^ sb, 31'd0};
                        end else begin
                            man_next    = prod;
                            exp_next    = a_e + b_e - 12'sd127;
                            sign_next   = sa ^ sb;
                            sticky_next = 1'b0;
                            state_next  = F_NORM;
                        end
                    end
                    FOP_SUB: begin
                        if (a_nan) begin
                            res_next = a_reg | QUIET_BIT;
                        end else if (b_nan) begin
                            res_next = b_reg | QUIET_BIT;
                        end else if (a_inf && b_inf) begin
                            res_next = (sa == bs_eff) ? a_reg : QNAN_DEF;
                        end else if (a_inf) begin
                            res_next = a_reg;
                        end else if (b_inf) begin
                            res_next = {bs_eff, b_reg[30:0]};
                        end else if (a_zero && b_zero) begin
                            res_next = {sa & bs_eff, 31'd0};
                        end else if (a_zero) begin
                            res_next = {bs_eff, b_reg[30:0]};
                        end else if (b_zero) begin
                            res_next = a_reg;
                        end else begin
                            esub_next  = sa ^ bs_eff;
                            ma_next    = a_big ? a_man : b_man;
                            mb_next    = a_big ? b_man : a_man;
                            ea_next    = a_big ? a_e : b_e;
                            eb_next    = a_big ? b_e : a_e;
                            sign_next  = a_big ? sa : bs_eff;
                            state_next = F_ALIGN;
                        end
                    end
                    FOP_DIV: begin
                        if (b_zero) begin
                            res_next = (a_nan || a_zero) ? QNAN_POS : {sa ^ sb, 8'hFF, 23'd0};
                        end else if (a_nan) begin
                            res_next = a_reg | QUIET_BIT;
                        end else if (b_nan) begin
                            res_next = b_reg | QUIET_BIT;
                        end else if (a_inf && b_inf) begin
                            res_next = QNAN_DEF;
                        end else if (a_inf) begin
                            res_next = {sa ^ sb, 8'hFF, 23'd0};
                        end else if (b_inf || a_zero) begin
                            res_next = {sa ^ sb, 31'd0};
                        end else begin
                            ma_next    = a_man;
                            mb_next    = b_man;
                            ea_next    = a_e;
                            eb_next    = b_e;
                            sign_next  = sa ^ sb;
                            state_next = F_PRENORM;
                        end
                    end
                    default: begin
                        res_next = QNAN_DEF;
                    end
                endcase
            end
            F_ALIGN: begin
                if (sum_m == 48'd0) begin
                    res_next   = 32'd0;
                    state_next = F_DONE;
                end else begin
                    man_next    = sum_m;
                    exp_next    = ea_reg;
                    sticky_next = 1'b0;
                    state_next  = F_NORM;
                end
            end
            F_PRENORM: begin
                if (!ma_reg[23]) begin
                    ma_next = {ma_reg[22:0], 1'b0};
                    ea_next = ea_reg - 12'sd1;
                end else if (!mb_reg[23]) begin
                    mb_next = {mb_reg[22:0], 1'b0};
                    eb_next = eb_reg - 12'sd1;
                end else begin
                    exp_next   = ea_reg - eb_reg + 12'sd127;
                    rem_next   = {2'b0, ma_reg};
                    quo_next   = 26'd0;
                    cnt_next   = 5'd0;
                    state_next = F_DIVIDE;
                end
            end
            F_DIVIDE: begin
                quo_next = {quo_reg[24:0], rem_ge};
                rem_next = {rem_diff[24:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd25) begin
                    man_next    = {1'b0, quo_reg[24:0], rem_ge, 21'd0};
                    sticky_next = rem_diff != 26'd0;
                    state_next  = F_NORM;
                end
            end
            F_NORM: begin
                if (man_reg[47] || (exp_reg < 12'sd1)) begin
                    sticky_next = sticky_reg | man_reg[0];
                    man_next    = {1'b0, man_reg[47:1]};
                    exp_next    = exp_reg + 12'sd1;
                end else if (!man_reg[46] && (exp_reg > 12'sd1)) begin
                    man_next = {man_reg[46:0], 1'b0};
                    exp_next = exp_reg - 12'sd1;
                end else begin
                    state_next = F_ROUND;
                end
            end
            F_ROUND: begin
                res_next   = rounded;
                state_next = F_DONE;
            end
            F_DONE: begin
                state_next = F_IDLE;
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        op_reg     <= op_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        sign_reg   <= sign_next;
        esub_reg   <= esub_next;
        exp_reg    <= exp_next;
        man_reg    <= man_next;
        sticky_reg <= sticky_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        ea_reg     <= ea_next;
        eb_reg     <= eb_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        res_reg    <= res_next;
    end

    assign done   = state_reg == F_DONE;
    assign result = res_reg;

endmodule

### sim/gauss_jordan_solver_core_tb.sv
module gauss_jordan_solver_core_tb
    import gjs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXN = 32;
    localparam int DEPTH = MAXN * (MAXN + 1);
    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam int SETTLE = 40;
    localparam logic [31:0] INF_BITS = 32'h7F80_0000;
    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] value;
        logic [4:0]  index;
        logic        last;
    } solution_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [5:0]  cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_coefficient = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_solution_value;
    logic [4:0]  m_unknown_index;
    logic        m_last_value;

    logic [31:0] coeff_ram [0:DEPTH-1];
    int          size_n = MAXN;
    int          loaded = 0;
    solution_t   solutions_due[$];
    int          mismatches = 0;
    int          items_sent = 0;
    longint      cycles = 0;
    bit          rx_hold = 1'b0;
    bit          no_idle = 1'b0;

    gauss_jordan_solver_core #(.MAX_UNKNOWNS(MAXN)) uut (
        .aclk, .aresetn, .cfg_we, .cfg_wdata,
        .s_valid, .s_ready, .s_coefficient,
        .m_valid, .m_ready, .m_solution_value, .m_unknown_index, .m_last_value
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ---------------- single precision arithmetic ----------------
    function automatic bit is_nan(logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] != 0;
    endfunction

    function automatic bit is_inf(logic [31:0] x);
        return x[30:0] == INF_BITS[30:0];
    endfunction

    function automatic bit is_zero(logic [31:0] x);
        return x[30:0] == 0;
    endfunction

    function automatic real sp_to_real(logic [31:0] x);
        real r;
        if (x[30:23] == 0) begin
            if (x[22:0] == 0) return $bitstoreal({x[31], 63'b0});
            r = real'(x[22:0]) * (2.0 ** (-149));
            return x[31] ? -r : r;
        end
        return $bitstoreal({x[31], 11'(int'(x[30:23]) - 127 + 1023), x[22:0], 29'b0});
    endfunction

    function automatic logic [31:0] real_to_sp(real r);
        logic [63:0] d;
        logic [63:0] mant, kept, rem, half;
        int e, shift;
        d = $realtobits(r);
        if (d[62:52] == 0) return {d[63], 31'b0};
        e = int'(d[62:52]) - 1023;
        if (e > 127) return {d[63], INF_BITS[30:0]};
        mant = {11'b0, 1'b1, d[51:0]};
        shift = (e >= -126) ? 29 : 29 + (-126 - e);
        if (shift > 60) return {d[63], 31'b0};
        kept = mant >> shift;
        rem = mant - (kept << shift);
        half = 64'd1 << (shift - 1);
        if (rem > half || (rem == half && kept[0])) kept = kept + 1;
        if (e >= -126) begin
            if (kept == 64'd1 << 24) begin
                kept = kept >> 1;
                e++;
            end
            if (e > 127) return {d[63], INF_BITS[30:0]};
            return {d[63], 8'(e + 127), kept[22:0]};
        end
        return {d[63], 31'(kept)};
    endfunction

    function automatic logic [31:0] sp_mul(logic [31:0] a, logic [31:0] b);
        if (is_nan(a)) return a | QUIET_BIT;
        if (is_nan(b)) return b | QUIET_BIT;
        if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) return QNAN_DEF;
        if (is_inf(a) || is_inf(b)) return ((a ^ b) & SIGN_BIT) | INF_BITS;
        return real_to_sp(sp_to_real(a) * sp_to_real(b));
    endfunction

    function automatic logic [31:0] sp_sub(logic [31:0] a, logic [31:0] b);
        if (is_nan(a)) return a | QUIET_BIT;
        if (is_nan(b)) return b | QUIET_BIT;
        if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? QNAN_DEF : a;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b ^ SIGN_BIT;
        return real_to_sp(sp_to_real(a) - sp_to_real(b));
    endfunction

    function automatic logic [31:0] sp_div(logic [31:0] a, logic [31:0] b);
        if (is_zero(b)) begin
            if (is_nan(a) || is_zero(a)) return QNAN_POS;
            return ((a ^ b) & SIGN_BIT) | INF_BITS;
        end
        if (is_nan(a)) return a | QUIET_BIT;
        if (is_nan(b)) return b | QUIET_BIT;
        if (is_inf(a) && is_inf(b)) return QNAN_DEF;
        if (is_inf(a)) return ((a ^ b) & SIGN_BIT) | INF_BITS;
        if (is_inf(b)) return (a ^ b) & SIGN_BIT;
        return real_to_sp(sp_to_real(a) / sp_to_real(b));
    endfunction

    // ---------------- solver prediction ----------------
    function automatic void solve_and_queue();
        int w, i, j, k;
        logic [31:0] pivot, factor;
        solution_t s;
        w = size_n + 1;
        for (i = 0; i < size_n; i++) begin
            pivot = coeff_ram[i*w + i];
            for (k = 0; k < w; k++) coeff_ram[i*w + k] = sp_div(coeff_ram[i*w + k], pivot);
            for (j = 0; j < size_n; j++) begin
                if (j == i) continue;
                factor = coeff_ram[j*w + i];
                for (k = 0; k < w; k++)
                    coeff_ram[j*w + k] = sp_sub(coeff_ram[j*w + k],
                                                sp_mul(coeff_ram[i*w + k], factor));
            end
        end
        for (i = 0; i < size_n; i++) begin
            s.value = coeff_ram[i*w + size_n];
            s.index = 5'(i);
            s.last = (i + 1 == size_n);
            solutions_due = {solutions_due, s};
        end
    endfunction

    function automatic void load_coefficient(logic [31:0] c);
        int total;
        total = size_n * (size_n + 1);
        if (loaded >= total) loaded = 0;
        coeff_ram[loaded] = c;
        loaded++;
        if (loaded == total) begin
            solve_and_queue();
            loaded = 0;
        end
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic int pick_gap();
        int p;
        if (no_idle) return 0;
        p = $urandom_range(99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(3, 1);
        return $urandom_range(60, 15);
    endfunction

    function automatic logic [31:0] nice_float();
        return {1'($urandom), 8'($urandom_range(133, 120)), 23'($urandom)};
    endfunction

    task automatic send_coefficient(logic [31:0] c);
        int gap;
        s_valid <= 1'b1;
        s_coefficient <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        load_coefficient(c);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic idle_sender();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (solutions_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_size(int v);
        idle_sender();
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= 6'(v);
        @(posedge aclk);
        cfg_we <= 1'b0;
        size_n = (v == 0) ? 1 : (v > MAXN ? MAXN : v);
        loaded = 0;
        @(posedge aclk);
    endtask

    // well-formed: rows whose diagonal has the largest exponent; otherwise raw bit patterns mixed in
    task automatic send_matrix(bit raw);
        int r, c;
        logic [31:0] v;
        for (r = 0; r < size_n; r++) begin
            for (c = 0; c <= size_n; c++) begin
                if (raw && $urandom_range(3) == 0) v = $urandom;
                else if (c == r) v = {1'($urandom), 8'(135), 23'($urandom)};
                else v = nice_float();
                send_coefficient(v);
            end
        end
    endtask

    // ---------------- tests ----------------
    // at the reset size a partial load must not produce any result
    task automatic test_reset_size();
        repeat (120) send_coefficient(nice_float());
        idle_sender();
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic test_zero_pivot();
        write_size(1);
        send_coefficient(32'h0000_0000); send_coefficient(32'h40A0_0000);
        send_coefficient(32'h8000_0000); send_coefficient(32'h40A0_0000);
        send_coefficient(32'h0000_0000); send_coefficient(32'h0000_0000);
        send_coefficient(32'h0000_0000); send_coefficient(32'h7FC1_2345);
        send_coefficient(32'h4000_0000); send_coefficient(32'hFFFF_FFFF);
        send_coefficient(32'h0000_0001); send_coefficient(32'h7F7F_FFFF);
        send_coefficient(32'h7F80_0000); send_coefficient(32'hFF80_0000);
        send_coefficient(32'h3F80_0000); send_coefficient(32'h0000_0001);
        write_size(2);
        send_coefficient(32'h0000_0000); send_coefficient(32'h3F80_0000);
        send_coefficient(32'h4000_0000); send_coefficient(32'h3F80_0000);
        send_coefficient(32'h0000_0000); send_coefficient(32'h4040_0000);
        idle_sender();
    endtask

    task automatic test_size_limits();
        write_size(0);
        send_coefficient(32'h4080_0000); send_coefficient(32'h4100_0000);
        write_size(63);
        send_coefficient(nice_float());
        send_coefficient(nice_float());
        write_size(3);
        send_coefficient(nice_float());
        write_size(2);
        send_matrix(1'b0);
        idle_sender();
    endtask

    task automatic test_back_pressure();
        write_size(1);
        rx_hold = 1'b1;
        fork
            begin
                repeat (3000) @(posedge aclk);
                rx_hold = 1'b0;
            end
            repeat (40) send_matrix(1'b1);
        join
        idle_sender();
    endtask

    task automatic test_random();
        while (items_sent < 400) begin
            if ($urandom_range(9) == 0) no_idle = ~no_idle;
            write_size($urandom_range(4, 1));
            repeat ($urandom_range(3, 1)) send_matrix($urandom_range(4) == 0);
        end
        no_idle = 1'b0;
        idle_sender();
    endtask

    // ---------------- result side ----------------
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold) m_ready <= 1'b0;
            else if (no_idle) m_ready <= 1'b1;
            else if ($urandom_range(99) < 3) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(60, 15)) @(posedge aclk);
            end else m_ready <= ($urandom_range(99) < 75);
        end
    end

    always @(posedge aclk) begin
        solution_t want;
        if (aresetn && m_valid && m_ready) begin
            if (solutions_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: value %h index %0d last %b",
                             m_solution_value, m_unknown_index, m_last_value);
            end else begin
                want = solutions_due.pop_front();
                if (m_solution_value !== want.value || m_unknown_index !== want.index ||
                    m_last_value !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                 want.value, want.index, want.last,
                                 m_solution_value, m_unknown_index, m_last_value);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("gauss_jordan_solver_core_tb: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_size();
        test_zero_pivot();
        test_size_limits();
        test_back_pressure();
        test_random();
        wait_drained();
        if (mismatches == 0 && solutions_due.size() == 0)
            $display("gauss_jordan_solver_core_tb: done, clean");
        else
            $display("gauss_jordan_solver_core_tb: done, errors");
        $finish;
    end

endmodule

### sim.f
design/gjs_pkg.sv
design/gjs_ram.sv
design/gjs_fpu.sv
design/gauss_jordan_solver_core.sv
sim/gauss_jordan_solver_core_tb.sv
